>>> hw/rtl/ste_pkg.sv
// Package for the sample table expander: operation codes, status codes,
// register indexes and shared sizes. Used by every module in hw/rtl.
`default_nettype none
package ste_pkg;
   localparam int MaxSamplesDef = 4096;
   localparam int MaxRunsDef    = 256;
   localparam int MaxChunksDef  = 1024;

   localparam logic [2:0] FUNC_TIMING  = 3'd0;
   localparam logic [2:0] FUNC_OFFSET  = 3'd1;
   localparam logic [2:0] FUNC_CHUNK   = 3'd2;
   localparam logic [2:0] FUNC_SIZE    = 3'd3;
   localparam logic [2:0] FUNC_CPOS    = 3'd4;
   localparam logic [2:0] FUNC_SYNC    = 3'd5;
   localparam logic [2:0] FUNC_RESTART = 3'd6;
   localparam logic [2:0] FUNC_NEXT    = 3'd7;

   localparam logic [1:0] ST_SAMPLE = 2'd0;
   localparam logic [1:0] ST_WRITE  = 2'd1;
   localparam logic [1:0] ST_DONE   = 2'd2;
   localparam logic [1:0] ST_LAYOUT = 2'd3;

   localparam logic [2:0] REG_SAMPLE_TOTAL = 3'd0;
   localparam logic [2:0] REG_UNIFORM_SIZE = 3'd1;
   localparam logic [2:0] REG_TIMING_RUNS  = 3'd2;
   localparam logic [2:0] REG_OFFSET_RUNS  = 3'd3;
   localparam logic [2:0] REG_CHUNK_RUNS   = 3'd4;
   localparam logic [2:0] REG_CHUNK_TOTAL  = 3'd5;
   localparam logic [2:0] REG_SIZE_TOTAL   = 3'd6;
   localparam logic [2:0] REG_SYNC_PRESENT = 3'd7;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load;       // register the request and read stores
      logic write;      // perform a table write
      logic restart;    // reset walk state
      logic chunk_rd;   // read chunk store, chunk run stores
      logic chunk_adv;  // run pointer advance step
      logic chunk_take; // take chunk: chunk_left, offset, walk_chunk
      logic trun_skip;  // skip exhausted timing run
      logic crun_skip;  // skip exhausted offset run
      logic emit;       // produce a sample record and step
   } ste_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic clearing;
      logic is_next;
      logic exhausted;
      logic no_layout;
      logic chunk_left_zero;
      logic chunks_out;
      logic can_adv;
      logic t_skip;
      logic c_skip;
   } ste_stat_type;
endpackage
`default_nettype wire

>>> hw/rtl/ste_ctrl.sv
// Controller state machine for the sample table expander.
// Depends on ste_pkg for command and status types.
`default_nettype none
module ste_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire ste_pkg::ste_stat_type stat,
   output ste_pkg::ste_cmd_type       cmd,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_status
);
   import ste_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_CHUNK_RD, S_CHUNK_ADV, S_RUNS, S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic busy_ff, busy_in;
   logic valid_ff, valid_in;
   logic [1:0] status_ff, status_in;

   always_comb begin
      state_in  = state_ff;
      busy_in   = busy_ff;
      valid_in  = 1'b0;
      status_in = status_ff;
      cmd       = '0;
      case (state_ff)
         S_CLEAR: begin
            // Held busy while the keyframe map is cleared after reset.
            if (!stat.clearing) begin
               state_in = S_IDLE;
               busy_in  = 1'b0;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
               busy_in  = 1'b1;
            end
         end
         S_DECODE: begin
            if (!stat.is_next) begin
               cmd.write = 1'b1;
               valid_in  = 1'b1;
               status_in = ST_WRITE;
               state_in  = S_IDLE;
               busy_in   = 1'b0;
            end else if (stat.exhausted) begin
               valid_in = 1'b1; status_in = ST_DONE;
               state_in = S_IDLE; busy_in = 1'b0;
            end else if (stat.no_layout) begin
               valid_in = 1'b1; status_in = ST_LAYOUT;
               state_in = S_IDLE; busy_in = 1'b0;
            end else if (stat.chunk_left_zero) begin
               state_in = S_CHUNK_RD;
            end else begin
               state_in = S_RUNS;
            end
         end
         S_CHUNK_RD: begin
            if (stat.chunks_out) begin
               valid_in = 1'b1; status_in = ST_LAYOUT;
               state_in = S_IDLE; busy_in = 1'b0;
            end else begin
               cmd.chunk_rd = 1'b1;
               state_in = S_CHUNK_ADV;
            end
         end
         S_CHUNK_ADV: begin
            // Walks the run pointer one run per cycle, then takes the chunk.
            if (stat.can_adv) begin
               cmd.chunk_adv = 1'b1;
            end else begin
               cmd.chunk_take = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_RUNS: begin
            if (stat.t_skip || stat.c_skip) begin
               cmd.trun_skip = stat.t_skip;
               cmd.crun_skip = stat.c_skip;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            valid_in = 1'b1; status_in = ST_SAMPLE;
            state_in = S_IDLE; busy_in = 1'b0;
         end
         default: begin
            state_in = S_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         busy_ff   <= 1'b1;
         valid_ff  <= 1'b0;
         status_ff <= ST_SAMPLE;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= busy_in;
         valid_ff  <= valid_in;
         status_ff <= status_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_valid  = valid_ff;
   assign rsp_status = status_ff;

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("start not taken");
   a_emit_sample: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (rsp_valid && rsp_status == ST_SAMPLE)) else $error("emit lost");
endmodule
`default_nettype wire

>>> hw/rtl/ste_datapath.sv
// Datapath of the sample table expander: configuration registers, table
// memories, walk state and result registers. Depends on ste_pkg.
`default_nettype none
module ste_datapath #(
   parameter int MAX_SAMPLES = ste_pkg::MaxSamplesDef,
   parameter int MAX_RUNS    = ste_pkg::MaxRunsDef,
   parameter int MAX_CHUNKS  = ste_pkg::MaxChunksDef
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ste_pkg::ste_cmd_type  cmd,
   output ste_pkg::ste_stat_type      stat,
   input  wire logic [2:0]            req_func,
   input  wire logic [11:0]           req_entry_index,
   input  wire logic [31:0]           req_run_length,
   input  wire logic [31:0]           req_entry_word,
   input  wire logic signed [32:0]    req_comp_offset,
   input  wire logic [63:0]           req_chunk_position,
   input  wire logic                  cfg_we,
   input  wire logic [2:0]            cfg_idx,
   input  wire logic [31:0]           cfg_data,
   output logic [31:0]                cfg_rdata,
   output logic [11:0]                out_sample_index,
   output logic [63:0]                out_byte_addr,
   output logic [31:0]                out_sample_bytes,
   output logic [63:0]                out_decode_time,
   output logic [31:0]                out_duration,
   output logic signed [32:0]         out_pres_delta,
   output logic                       out_keyframe
);
   import ste_pkg::*;

   localparam int SW = $clog2(MAX_SAMPLES);
   localparam int SA = (SW < 1) ? 1 : SW;
   localparam int RW = $clog2(MAX_RUNS);
   localparam int RA = (RW < 1) ? 1 : RW;
   localparam int CW = $clog2(MAX_CHUNKS);
   localparam int CA = (CW < 1) ? 1 : CW;
   localparam int SCW = $clog2(MAX_SAMPLES + 1);
   localparam int RCW = $clog2(MAX_RUNS + 1);
   localparam int CCW = $clog2(MAX_CHUNKS + 1);

   // Configuration registers.
   logic [12:0] sample_total_ff, size_total_ff;
   logic [31:0] uniform_size_ff;
   logic [8:0]  timing_runs_ff, offset_runs_ff, chunk_runs_ff;
   logic [10:0] chunk_total_ff;
   logic        sync_present_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_total_ff <= '0; uniform_size_ff <= '0; timing_runs_ff <= '0;
         offset_runs_ff <= '0; chunk_runs_ff <= '0; chunk_total_ff <= '0;
         size_total_ff <= '0; sync_present_ff <= 1'b0;
      end else if (cfg_we) begin
         case (cfg_idx)
            REG_SAMPLE_TOTAL: sample_total_ff <= cfg_data[12:0];
            REG_UNIFORM_SIZE: uniform_size_ff <= cfg_data;
            REG_TIMING_RUNS:  timing_runs_ff  <= cfg_data[8:0];
            REG_OFFSET_RUNS:  offset_runs_ff  <= cfg_data[8:0];
            REG_CHUNK_RUNS:   chunk_runs_ff   <= cfg_data[8:0];
            REG_CHUNK_TOTAL:  chunk_total_ff  <= cfg_data[10:0];
            REG_SIZE_TOTAL:   size_total_ff   <= cfg_data[12:0];
            REG_SYNC_PRESENT: sync_present_ff <= cfg_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         REG_SAMPLE_TOTAL: cfg_rdata = {19'd0, sample_total_ff};
         REG_UNIFORM_SIZE: cfg_rdata = uniform_size_ff;
         REG_TIMING_RUNS:  cfg_rdata = {23'd0, timing_runs_ff};
         REG_OFFSET_RUNS:  cfg_rdata = {23'd0, offset_runs_ff};
         REG_CHUNK_RUNS:   cfg_rdata = {23'd0, chunk_runs_ff};
         REG_CHUNK_TOTAL:  cfg_rdata = {21'd0, chunk_total_ff};
         REG_SIZE_TOTAL:   cfg_rdata = {19'd0, size_total_ff};
         REG_SYNC_PRESENT: cfg_rdata = {31'd0, sync_present_ff};
         default:          cfg_rdata = '0;
      endcase
   end

   // Capped counts.
   function automatic logic [31:0] cap32(input logic [31:0] v, input logic [31:0] lim);
      cap32 = (v < lim) ? v : lim;
   endfunction
   logic [31:0] n_smp, n_chk, n_cr, n_tr, n_or, n_sz;
   assign n_smp = cap32({19'd0, sample_total_ff}, 32'(MAX_SAMPLES));
   assign n_chk = cap32({21'd0, chunk_total_ff}, 32'(MAX_CHUNKS));
   assign n_cr  = cap32({23'd0, chunk_runs_ff}, 32'(MAX_RUNS));
   assign n_tr  = cap32({23'd0, timing_runs_ff}, 32'(MAX_RUNS));
   assign n_or  = cap32({23'd0, offset_runs_ff}, 32'(MAX_RUNS));
   assign n_sz  = cap32({19'd0, size_total_ff}, 32'(MAX_SAMPLES));

   // Registered request.
   logic [2:0]  func_ff;
   logic [11:0] idx_ff;
   logic [31:0] len_ff, word_ff;
   logic [32:0] coff_ff;
   logic [63:0] cpos_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func; idx_ff <= req_entry_index;
         len_ff <= req_run_length; word_ff <= req_entry_word;
         coff_ff <= req_comp_offset; cpos_ff <= req_chunk_position;
      end
   end

   // Walk state.
   logic [SCW-1:0] walk_sample_ff;
   logic [CCW-1:0] walk_chunk_ff;
   logic [31:0]    chunk_left_ff;
   logic [RA-1:0]  rptr_ff;
   logic [63:0]    running_offset_ff, time_acc_ff;
   logic [RCW-1:0] trun_ff, crun_ff;
   logic [31:0]    tpos_ff, cpos_walk_ff;

   // Memories.
   logic [63:0] timing_mem [MAX_RUNS];
   logic [64:0] comp_mem   [MAX_RUNS];
   logic [31:0] crun_per_mem   [MAX_RUNS];
   logic [31:0] crun_first_b   [MAX_RUNS];
   logic [31:0] size_mem   [MAX_SAMPLES];
   logic [63:0] chunk_mem  [MAX_CHUNKS];
   logic        key_mem    [MAX_SAMPLES];

   logic idx_run_ok, idx_smp_ok, idx_chk_ok, sync_ok;
   assign idx_run_ok = {20'd0, idx_ff} < 32'(MAX_RUNS);
   assign idx_smp_ok = {20'd0, idx_ff} < 32'(MAX_SAMPLES);
   assign idx_chk_ok = {20'd0, idx_ff} < 32'(MAX_CHUNKS);
   assign sync_ok    = (word_ff >= 32'd1) && (word_ff <= 32'(MAX_SAMPLES));

   logic [31:0] wsync;
   assign wsync = word_ff - 32'd1;

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         if (func_ff == FUNC_TIMING && idx_run_ok)
            timing_mem[idx_ff[RA-1:0]] <= {len_ff, word_ff};
         if (func_ff == FUNC_OFFSET && idx_run_ok)
            comp_mem[idx_ff[RA-1:0]] <= {len_ff, coff_ff};
         if (func_ff == FUNC_CHUNK && idx_run_ok) begin
            crun_first_b[idx_ff[RA-1:0]]   <= len_ff;
            crun_per_mem[idx_ff[RA-1:0]]   <= word_ff;
         end
         if (func_ff == FUNC_SIZE && idx_smp_ok)
            size_mem[idx_ff[SA-1:0]] <= word_ff;
         if (func_ff == FUNC_CPOS && idx_chk_ok)
            chunk_mem[idx_ff[CA-1:0]] <= cpos_ff;
      end
   end

   // The keyframe map is cleared one entry per cycle after reset.
   logic          clr_run_ff;
   logic [SA-1:0] clr_addr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_run_ff  <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_run_ff) begin
         clr_addr_ff <= clr_addr_ff + SA'(1);
         if (clr_addr_ff == SA'(MAX_SAMPLES - 1)) clr_run_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_run_ff)
         key_mem[clr_addr_ff] <= 1'b0;
      else if (cmd.write && func_ff == FUNC_SYNC && sync_ok)
         key_mem[wsync[SA-1:0]] <= 1'b1;
   end

   // Registered reads: chunk data and the run looked at next.
   logic [63:0] chunk_rd_ff;
   logic [31:0] next_first_ff, cur_per_ff;
   logic [RA-1:0] rptr_c;
   logic [31:0] rnext32;
   assign rptr_c  = ({{(32-RA){1'b0}}, rptr_ff} >= n_cr) ? RA'(n_cr - 32'd1) : rptr_ff;
   assign rnext32 = {{(32-RA){1'b0}}, rptr_c} + 32'd1;

   always_ff @(posedge clock) begin
      if (cmd.chunk_rd)
         chunk_rd_ff <= chunk_mem[walk_chunk_ff[CA-1:0]];
      if (cmd.chunk_rd || cmd.chunk_adv) begin
         cur_per_ff    <= crun_per_mem[cmd.chunk_adv ? RA'(rnext32) : rptr_c];
         next_first_ff <= crun_first_b[cmd.chunk_adv ? RA'(rnext32 + 32'd1) : RA'(rnext32)];
      end
   end

   logic [32:0] cnum;
   assign cnum = {{(33-CCW){1'b0}}, walk_chunk_ff} + 33'd1;

   // Run reads through registered ports as well.
   logic [63:0] trun_rd_ff;
   logic [64:0] crun_rd_ff;
   logic [31:0] size_rd_ff;
   logic        key_rd_ff;
   logic [RCW-1:0] trun_nx, crun_nx;
   assign trun_nx = cmd.trun_skip ? trun_ff + RCW'(1) : trun_ff;
   assign crun_nx = cmd.crun_skip ? crun_ff + RCW'(1) : crun_ff;
   always_ff @(posedge clock) begin
      trun_rd_ff <= timing_mem[trun_nx[RA-1:0]];
      crun_rd_ff <= comp_mem[crun_nx[RA-1:0]];
      size_rd_ff <= size_mem[walk_sample_ff[SA-1:0]];
      key_rd_ff  <= key_mem[walk_sample_ff[SA-1:0]];
   end

   logic t_in, c_in;
   assign t_in = {{(32-RCW){1'b0}}, trun_ff} < n_tr;
   assign c_in = {{(32-RCW){1'b0}}, crun_ff} < n_or;

   logic [31:0] size_v;
   assign size_v = (uniform_size_ff != 32'd0) ? uniform_size_ff :
                   (({{(32-SCW){1'b0}}, walk_sample_ff} < n_sz) ? size_rd_ff : 32'd0);
   logic [31:0] dur_v;
   assign dur_v = t_in ? trun_rd_ff[31:0] : 32'd0;

   always_ff @(posedge clock) begin
      if (reset || (cmd.write && func_ff == FUNC_RESTART)) begin
         walk_sample_ff <= '0; walk_chunk_ff <= '0; chunk_left_ff <= '0;
         rptr_ff <= '0; running_offset_ff <= '0; time_acc_ff <= '0;
         trun_ff <= '0; crun_ff <= '0; tpos_ff <= '0; cpos_walk_ff <= '0;
      end else begin
         if (cmd.chunk_rd) rptr_ff <= rptr_c;
         if (cmd.chunk_adv) rptr_ff <= RA'(rnext32);
         if (cmd.chunk_take) begin
            chunk_left_ff     <= cur_per_ff;
            running_offset_ff <= chunk_rd_ff;
            walk_chunk_ff     <= walk_chunk_ff + CCW'(1);
         end
         if (cmd.trun_skip) begin trun_ff <= trun_nx; tpos_ff <= '0; end
         if (cmd.crun_skip) begin crun_ff <= crun_nx; cpos_walk_ff <= '0; end
         if (cmd.emit) begin
            running_offset_ff <= running_offset_ff + {32'd0, size_v};
            chunk_left_ff     <= chunk_left_ff - 32'd1;
            time_acc_ff       <= time_acc_ff + {32'd0, dur_v};
            if (t_in) tpos_ff <= tpos_ff + 32'd1;
            if (c_in) cpos_walk_ff <= cpos_walk_ff + 32'd1;
            walk_sample_ff    <= walk_sample_ff + SCW'(1);
         end
      end
   end

   // Result registers; zero unless a sample is emitted.
   always_ff @(posedge clock) begin
      out_sample_index <= '0; out_byte_addr <= '0; out_sample_bytes <= '0;
      out_decode_time <= '0; out_duration <= '0; out_pres_delta <= '0;
      out_keyframe <= 1'b0;
      if (cmd.emit) begin
         out_sample_index <= 12'({{(32-SCW){1'b0}}, walk_sample_ff});
         out_byte_addr    <= running_offset_ff;
         out_sample_bytes <= size_v;
         out_decode_time  <= time_acc_ff;
         out_duration     <= dur_v;
         out_pres_delta   <= c_in ? crun_rd_ff[32:0] : 33'd0;
         out_keyframe     <= sync_present_ff ? key_rd_ff : 1'b1;
      end
   end

   assign stat.clearing        = clr_run_ff;
   assign stat.is_next         = (func_ff == FUNC_NEXT);
   assign stat.exhausted       = {{(32-SCW){1'b0}}, walk_sample_ff} >= n_smp;
   assign stat.no_layout       = (n_chk == 32'd0) || (n_cr == 32'd0);
   assign stat.chunk_left_zero = (chunk_left_ff == 32'd0);
   assign stat.chunks_out      = {{(32-CCW){1'b0}}, walk_chunk_ff} >= n_chk;
   assign stat.can_adv         = ({{(32-RA){1'b0}}, rptr_ff} + 32'd1 < n_cr) &&
                                 ({1'b0, next_first_ff} <= cnum);
   assign stat.t_skip          = t_in && (tpos_ff >= trun_rd_ff[63:32]);
   assign stat.c_skip          = c_in && (cpos_walk_ff >= crun_rd_ff[64:33]);

   a_take_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.chunk_take |-> !stat.chunks_out) else $error("chunk past end");
   a_emit_has_chunk: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !stat.chunk_left_zero) else $error("emit without chunk");
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      clr_run_ff |-> !(cmd.write || cmd.load)) else $error("item during clear");
endmodule
`default_nettype wire

>>> hw/rtl/sample_table_expander.sv
// Top level of the sample table expander: APB register port, controller
// and datapath. Depends on ste_pkg, ste_ctrl and ste_datapath.
//
//   channel   direction  handshake
//   request   in         start, busy (accepted when start && !busy)
//   response  out        rsp_valid strobe, one cycle
//   config    in         APB psel/penable/pwrite, pready tied high
//
// Table writes, restart and end-of-track answers come from the decode state,
// layout answers from decode or chunk read. A sample passes decode, then for
// each chunk entered a chunk read, a run-pointer step per run passed and a
// chunk take, then a skip step for each exhausted time run, offset run or
// both passed together, then emit. Reset is synchronous and clears the walk
// at once; the keyframe map is then cleared one entry per cycle, with busy
// high until it is done. Results cannot be stalled.
`default_nettype none
module sample_table_expander #(
   parameter int MAX_SAMPLES = ste_pkg::MaxSamplesDef,
   parameter int MAX_RUNS    = ste_pkg::MaxRunsDef,
   parameter int MAX_CHUNKS  = ste_pkg::MaxChunksDef
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_func,
   input  wire logic [11:0]        req_entry_index,
   input  wire logic [31:0]        req_run_length,
   input  wire logic [31:0]        req_entry_word,
   input  wire logic signed [32:0] req_comp_offset,
   input  wire logic [63:0]        req_chunk_position,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic [11:0]             rsp_sample_index,
   output logic [63:0]             rsp_byte_addr,
   output logic [31:0]             rsp_sample_bytes,
   output logic [63:0]             rsp_decode_time,
   output logic [31:0]             rsp_duration,
   output logic signed [32:0]      rsp_pres_delta,
   output logic                    rsp_keyframe,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [4:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   import ste_pkg::*;

   ste_cmd_type  cmd;
   ste_stat_type stat;
   logic cfg_we;

   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite;

   ste_ctrl u_ctrl (
      .clock, .reset, .start, .busy, .stat, .cmd,
      .rsp_valid, .rsp_status
   );

   ste_datapath #(
      .MAX_SAMPLES(MAX_SAMPLES), .MAX_RUNS(MAX_RUNS), .MAX_CHUNKS(MAX_CHUNKS)
   ) u_dp (
      .clock, .reset, .cmd, .stat,
      .req_func, .req_entry_index, .req_run_length, .req_entry_word,
      .req_comp_offset, .req_chunk_position,
      .cfg_we, .cfg_idx(paddr[4:2]), .cfg_data(pwdata), .cfg_rdata(prdata),
      .out_sample_index(rsp_sample_index), .out_byte_addr(rsp_byte_addr),
      .out_sample_bytes(rsp_sample_bytes), .out_decode_time(rsp_decode_time),
      .out_duration(rsp_duration), .out_pres_delta(rsp_pres_delta),
      .out_keyframe(rsp_keyframe)
   );
endmodule
`default_nettype wire
